// ===== hw/rtl/memory_map_line_parser_core_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef MEMORY_MAP_LINE_PARSER_CORE_MACROS_SVH
`define MEMORY_MAP_LINE_PARSER_CORE_MACROS_SVH

// Checked only while out of reset.
`define MMLP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MMLP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/mmlp_pkg.sv =====
package mmlp_pkg;

  localparam int unsigned MAX_LINE_LEN = 4096;
  localparam int unsigned POS_W        = $clog2(MAX_LINE_LEN + 1);
  localparam int unsigned PATH_W       = 12;
  localparam int unsigned ACC_W        = 64;
  localparam int unsigned OUT_DATA_W   = 408;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_S     = 8'h73;

  localparam logic [2:0] PERM_LEN = 3'd4;

  typedef enum logic [3:0] {
    PH_BEGIN = 4'd0,
    PH_DASH  = 4'd1,
    PH_END   = 4'd2,
    PH_PERM  = 4'd3,
    PH_OFF   = 4'd4,
    PH_MAJ   = 4'd5,
    PH_COLON = 4'd6,
    PH_MIN   = 4'd7,
    PH_INO   = 4'd8,
    PH_GAP   = 4'd9,
    PH_PATH  = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_NUM   = 3'd1,
    ST_SEP   = 3'd2,
    ST_PERM  = 3'd3,
    ST_TRUNC = 3'd4
  } status_e;

  typedef struct packed {
    phase_e     phase;
    logic       digit_seen;
    logic [2:0] perm_count;
    logic [3:0] perm_bits;
    status_e    err;
    logic       path_hit;
    logic       retake;
    logic       hex_acc;
    logic       dec_acc;
  } step_t;

endpackage

// ===== hw/rtl/memory_map_line_parser_core.sv =====
// Memory-map line parser. The input stream carries one text byte per transfer
// in s_axis_tdata_i, with s_axis_tlast_i on the final byte of a line. For each
// line one result transfer leaves on the master side once the last byte has
// been taken; nothing is sent for the other bytes.
// A byte is parsed in the cycle it is accepted, so one byte is taken every
// cycle but for a held-off last byte; a line's result is valid in the cycle
// after its last byte. The next line may start in that cycle too.
// The result sits in a single output register. While it waits, further bytes
// of the next line are still taken; only a last byte is held off until the
// pending result has been transferred.
// Reset clears the parse state and the output valid; the first byte after
// reset starts a new line. Bytes at position 4096 and beyond are accepted but
// not parsed.
`include "memory_map_line_parser_core_macros.svh"

module memory_map_line_parser_core
  import mmlp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // line_char
  input  logic [7:0]            s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // begin_addr, end_addr, file_offset, dev_major, dev_minor, inode_number,
  // can_read, can_write, can_exec, is_shared, path_start, status, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  phase_e             phase_q, phase_d;
  logic               ds_q, ds_d;
  logic [2:0]         pc_q, pc_d;
  logic [3:0]         pb_q, pb_d;
  status_e            err_q, err_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PATH_W-1:0]  path_q, path_d;
  logic [ACC_W-1:0]   begin_q, begin_d, end_q, end_d, off_q, off_d;
  logic [ACC_W-1:0]   maj_q, maj_d, min_q, min_d, ino_q, ino_d;
  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic               s_acc;
  logic               last_acc;
  logic               in_range;
  logic               run;
  step_t              cur, s1, s2, fin;
  logic [3:0]         hex_digit;
  logic [ACC_W-1:0]   hex_next;
  logic [ACC_W-1:0]   dec_next;
  logic [POS_W-1:0]   pos_new;
  logic [PATH_W-1:0]  path_fin;
  status_e            err_fin;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
           (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic step_t take_char(input step_t st, input logic [7:0] c);
    step_t r;
    logic  sp;
    logic  dg;
    r          = st;
    r.path_hit = 1'b0;
    r.retake   = 1'b0;
    r.hex_acc  = 1'b0;
    r.dec_acc  = 1'b0;
    sp = (c == CH_SPACE) || (c == CH_TAB);
    dg = (c >= CH_0) && (c <= CH_9);
    unique case (st.phase)
      PH_BEGIN, PH_END, PH_OFF, PH_MAJ, PH_MIN: begin
        if (!(sp && !st.digit_seen)) begin
          if (is_hex(c)) begin
            r.hex_acc    = 1'b1;
            r.digit_seen = 1'b1;
          end else if (st.digit_seen) begin
            r.digit_seen = 1'b0;
            r.phase      = phase_e'(st.phase + 4'd1);
            r.retake     = 1'b1;
          end else begin
            r.err = ST_NUM;
          end
        end
      end
      PH_DASH, PH_COLON: begin
        if (!sp) begin
          if (c == ((st.phase == PH_DASH) ? CH_DASH : CH_COLON)) begin
            r.phase = phase_e'(st.phase + 4'd1);
          end else begin
            r.err = ST_SEP;
          end
        end
      end
      PH_PERM: begin
        if (sp) begin
          if (st.perm_count != 3'd0) begin
            if (st.perm_count < PERM_LEN) begin
              r.err = ST_PERM;
            end else begin
              r.phase = PH_OFF;
            end
          end
        end else if (st.perm_count < PERM_LEN) begin
          case (st.perm_count)
            3'd0: begin
              if (c == CH_R) r.perm_bits[0] = 1'b1;
              else if (c != CH_DASH) r.err = ST_PERM;
            end
            3'd1: begin
              if (c == CH_W) r.perm_bits[1] = 1'b1;
              else if (c != CH_DASH) r.err = ST_PERM;
            end
            3'd2: begin
              if (c == CH_X) r.perm_bits[2] = 1'b1;
              else if (c != CH_DASH) r.err = ST_PERM;
            end
            default: begin
              if (c == CH_S) r.perm_bits[3] = 1'b1;
              else if (c != CH_P) r.err = ST_PERM;
            end
          endcase
          r.perm_count = st.perm_count + 3'd1;
        end
      end
      PH_INO: begin
        if (!(sp && !st.digit_seen)) begin
          if (dg) begin
            r.dec_acc    = 1'b1;
            r.digit_seen = 1'b1;
          end else if (st.digit_seen) begin
            r.digit_seen = 1'b0;
            r.phase      = PH_GAP;
            r.retake     = 1'b1;
          end else begin
            r.err = ST_NUM;
          end
        end
      end
      PH_GAP: begin
        if (!sp) begin
          r.path_hit = 1'b1;
          r.phase    = PH_PATH;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i || !s_axis_tlast_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign last_acc        = s_acc && s_axis_tlast_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    in_range = pos_q < POS_W'(MAX_LINE_LEN);
    run      = in_range && (err_q == ST_OK);

    cur = '{phase: phase_q, digit_seen: ds_q, perm_count: pc_q, perm_bits: pb_q,
            err: err_q, path_hit: 1'b0, retake: 1'b0, hex_acc: 1'b0, dec_acc: 1'b0};
    s1  = take_char(cur, s_axis_tdata_i);
    s2  = s1.retake ? take_char(s1, s_axis_tdata_i) : s1;
    fin = run ? s2 : cur;

    if (s_axis_tdata_i <= CH_9) begin
      hex_digit = s_axis_tdata_i[3:0];
    end else begin
      hex_digit = s_axis_tdata_i[3:0] + 4'd9;
    end
    case (phase_q)
      PH_BEGIN: hex_next = {begin_q[ACC_W-5:0], hex_digit};
      PH_END:   hex_next = {end_q[ACC_W-5:0], hex_digit};
      PH_OFF:   hex_next = {off_q[ACC_W-5:0], hex_digit};
      PH_MAJ:   hex_next = {maj_q[ACC_W-5:0], hex_digit};
      default:  hex_next = {min_q[ACC_W-5:0], hex_digit};
    endcase
    dec_next = {ino_q[ACC_W-4:0], 3'b000} + {ino_q[ACC_W-2:0], 1'b0} +
               ACC_W'(s_axis_tdata_i[3:0]);

    begin_d = begin_q;
    end_d   = end_q;
    off_d   = off_q;
    maj_d   = maj_q;
    min_d   = min_q;
    ino_d   = ino_q;
    if (run && s1.hex_acc) begin
      case (phase_q)
        PH_BEGIN: begin_d = hex_next;
        PH_END:   end_d   = hex_next;
        PH_OFF:   off_d   = hex_next;
        PH_MAJ:   maj_d   = hex_next;
        default:  min_d   = hex_next;
      endcase
    end
    if (run && s1.dec_acc) begin
      ino_d = dec_next;
    end

    path_d  = (run && s2.path_hit) ? pos_q[PATH_W-1:0] : path_q;
    pos_new = in_range ? pos_q + POS_W'(1) : pos_q;

    err_fin  = fin.err;
    path_fin = path_d;
    if (fin.err == ST_OK) begin
      if (fin.phase == PH_PATH) begin
        path_fin = path_d;
      end else if (fin.phase == PH_GAP || (fin.phase == PH_INO && fin.digit_seen)) begin
        path_fin = pos_new[PATH_W-1:0];
      end else begin
        err_fin = ST_TRUNC;
      end
    end

    out_data_d = {5'd0, err_fin, path_fin, fin.perm_bits[3], fin.perm_bits[2],
                  fin.perm_bits[1], fin.perm_bits[0], ino_d, min_d, maj_d, off_d,
                  end_d, begin_d};

    phase_d = fin.phase;
    ds_d    = fin.digit_seen;
    pc_d    = fin.perm_count;
    pb_d    = fin.perm_bits;
    err_d   = fin.err;
    pos_d   = pos_new;
    if (s_axis_tlast_i) begin
      phase_d = PH_BEGIN;
      ds_d    = 1'b0;
      pc_d    = 3'd0;
      pb_d    = 4'd0;
      err_d   = ST_OK;
      pos_d   = '0;
      path_d  = '0;
      begin_d = '0;
      end_d   = '0;
      off_d   = '0;
      maj_d   = '0;
      min_d   = '0;
      ino_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BEGIN;
      ds_q        <= 1'b0;
      pc_q        <= 3'd0;
      pb_q        <= 4'd0;
      err_q       <= ST_OK;
      pos_q       <= '0;
      path_q      <= '0;
      begin_q     <= '0;
      end_q       <= '0;
      off_q       <= '0;
      maj_q       <= '0;
      min_q       <= '0;
      ino_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        phase_q <= phase_d;
        ds_q    <= ds_d;
        pc_q    <= pc_d;
        pb_q    <= pb_d;
        err_q   <= err_d;
        pos_q   <= pos_d;
        path_q  <= path_d;
        begin_q <= begin_d;
        end_q   <= end_d;
        off_q   <= off_d;
        maj_q   <= maj_d;
        min_q   <= min_d;
        ino_q   <= ino_d;
      end
      if (s_acc && s_axis_tlast_i) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast_i) begin
      out_data_q <= out_data_d;
    end
  end

  `MMLP_ASSERT(a_result_from_last, $rose(m_axis_tvalid_o) |-> $past(last_acc), "no last byte")
  `MMLP_ASSERT(a_line_restart, last_acc |=> phase_q == PH_BEGIN && pos_q == '0, "state kept")
  `MMLP_ASSERT(a_no_overwrite, out_valid_q && !m_axis_tready_i |-> !last_acc, "overwrite")
  `MMLP_ASSERT(a_perm_count, pc_q <= PERM_LEN, "perm count beyond four")
  `MMLP_ASSERT(a_pos_bound, pos_q <= POS_W'(MAX_LINE_LEN), "position beyond line limit")
  `MMLP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o, "valid during reset")

endmodule
